// ===== design/ttm_pkg.sv =====
// ----------------------------------------------------------------------------
// ttm_pkg
// Shared types and constants of the temperature trend monitor.
// ----------------------------------------------------------------------------
package ttm_pkg;

  localparam int unsigned TEMP_W      = 16;  // sample and result width
  localparam int unsigned WIN_W       = 7;   // window_length register width
  localparam int unsigned THR_W       = 15;  // trend_threshold register width
  localparam int unsigned CFG_W       = 16;  // widest register
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned OUT_TDATA_W = 56;  // 52 payload bits, byte padded

  // Fahrenheit conversion: (t - 32*16) * 5 / 9
  localparam int          F_OFFSET    = 32 * 16;
  localparam int unsigned F_MAG_W     = 18;  // |(t - 512) * 5| fits 18 bits
  // Divide by 9 as multiply by ceil(2^21 / 9), exact for inputs below 2^21
  localparam int unsigned RECIP_SH    = 21;
  localparam logic [F_MAG_W-1:0] RECIP_K = F_MAG_W'(((1 << RECIP_SH) + 8) / 9);
  localparam int unsigned PROD_W      = 2 * F_MAG_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_HIGH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LOW        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TREND_THRESHOLD = 2'd3;

  localparam logic [WIN_W-1:0]  WINDOW_RST    = 7'd10;
  localparam logic [TEMP_W-1:0] WARN_HIGH_RST = 16'd800;
  localparam logic [TEMP_W-1:0] WARN_LOW_RST  = 16'd160;
  localparam logic [THR_W-1:0]  THR_RST       = 15'd6;

  typedef enum logic [1:0] {
    TREND_STABLE  = 2'd0,
    TREND_RISING  = 2'd1,
    TREND_FALLING = 2'd2
  } trend_e;

endpackage

// ===== design/ttm_divider.sv =====
// ----------------------------------------------------------------------------
// ttm_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttm_divider #(
  parameter int unsigned DVD_W = 22,
  parameter int unsigned DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CNT_W'(DVD_W);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/ttm_ring.sv =====
// ----------------------------------------------------------------------------
// ttm_ring
// Sample ring: single write port, registered read port.
// ----------------------------------------------------------------------------
module ttm_ring #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [ttm_pkg::TEMP_W-1:0]  wdata_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [ttm_pkg::TEMP_W-1:0]  rdata_o
);

  logic [ttm_pkg::TEMP_W-1:0] mem [DEPTH];
  logic [ttm_pkg::TEMP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/temperature_trend_monitor_core.sv =====
// ----------------------------------------------------------------------------
// temperature_trend_monitor_core
// Temperature conditioning: F->C conversion, running max, moving average,
// trend and limit flags.
// ----------------------------------------------------------------------------
// One sample in, one result out. A sample that completes the window passes,
// after the input transaction, through the Fahrenheit product (multiply by
// reciprocal of 9) and the ring read, the window update, the load of the
// serial divider, the divide at one quotient bit per cycle (dividend of sum
// width minus one, 22 bits at MAX_WINDOW = 64) up to its done flag, the trend
// compare and the load of the output register. Samples that do not fill the
// window skip the divide. The input is ready only while the sequencer is
// idle, which starts the cycle after the output register is loaded, so a new
// sample is not taken before the last one has reached the output register.
// The result sits in an output register, so the next sample is taken while a
// result still waits on m_axis_tready; that sample then holds in the output
// stage until the waiting result leaves. The ring has no reset; a value read
// from it is only used at an entry written since the last window_length
// write. Configuration writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module temperature_trend_monitor_core #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [ttm_pkg::TEMP_W-1:0]          s_axis_tdata,  // [15:0] temp_value
  input  logic                                s_axis_tuser,  // [0] unit_is_c
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [15:0] celsius, [31:16] max_seen, [47:32] average, [48] average_valid,
  // [50:49] trend, [51] out_of_range, [55:52] zero
  output logic [ttm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [ttm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ttm_pkg::CFG_W-1:0]           cfg_wdata_i
);

  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W = ttm_pkg::TEMP_W + PTR_W + 1;
  localparam int unsigned DVD_W = SUM_W - 1;
  localparam int unsigned TW    = ttm_pkg::TEMP_W;
  localparam int unsigned WW    = ttm_pkg::WIN_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CONV   = 7'b0000010,
    S_UPD    = 7'b0000100,
    S_DSTART = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_TREND  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [WW-1:0]               win_q, win_d;
  logic signed [TW-1:0]        warn_hi_q, warn_hi_d;
  logic signed [TW-1:0]        warn_lo_q, warn_lo_d;
  logic [ttm_pkg::THR_W-1:0]   thr_q, thr_d;

  // window state
  logic [PTR_W-1:0]            ptr_q, ptr_d;
  logic [WW-1:0]               fill_q, fill_d;
  logic signed [SUM_W-1:0]     sum_q, sum_d;
  logic signed [TW-1:0]        max_q, max_d;
  logic signed [TW-1:0]        prev_q, prev_d;
  logic                        prev_vld_q, prev_vld_d;

  // per-sample working registers
  logic signed [TW-1:0]        temp_q, temp_d;
  logic                        isc_q, isc_d;
  logic [ttm_pkg::PROD_W-1:0]  prod_q, prod_d;
  logic                        fneg_q, fneg_d;
  logic signed [TW-1:0]        cel_q, cel_d;
  logic                        oor_q, oor_d;
  logic                        sneg_q, sneg_d;
  logic signed [TW-1:0]        avg_q, avg_d;
  logic                        avg_vld_q, avg_vld_d;
  ttm_pkg::trend_e             trend_q, trend_d;

  // output register
  logic                              m_vld_q, m_vld_d;
  logic [ttm_pkg::OUT_TDATA_W-1:0]   m_data_q, m_data_d;

  // effective window length: zero acts as one, clamp to MAX_WINDOW
  logic [WW-1:0] len;
  assign len = (win_q == '0) ? WW'(1) :
               (32'(win_q) > MAX_WINDOW) ? WW'(MAX_WINDOW) : win_q;

  // ring pointer wrapped for a shortened window
  logic [PTR_W-1:0] ptr_adj;
  assign ptr_adj = (32'(ptr_q) >= 32'(len)) ? '0 : ptr_q;

  // Fahrenheit front end: |(t - 512) * 5|
  logic signed [TW:0]                 f_off;
  logic signed [ttm_pkg::F_MAG_W:0]   f_x5;
  logic [ttm_pkg::F_MAG_W-1:0]        f_mag;
  assign f_off = {temp_d[TW-1], temp_d} - (TW+1)'(ttm_pkg::F_OFFSET);
  assign f_x5  = ((ttm_pkg::F_MAG_W+1)'(f_off) <<< 2) + (ttm_pkg::F_MAG_W+1)'(f_off);
  assign f_mag = f_x5[ttm_pkg::F_MAG_W] ? ttm_pkg::F_MAG_W'(-f_x5)
                                        : f_x5[ttm_pkg::F_MAG_W-1:0];

  // quotient of the divide by 9
  logic [TW-2:0]        f_quo;
  logic signed [TW-1:0] f_cel;
  logic signed [TW-1:0] cel_now;
  assign f_quo   = prod_q[ttm_pkg::RECIP_SH +: (TW-1)];
  assign f_cel   = fneg_q ? -$signed({1'b0, f_quo}) : $signed({1'b0, f_quo});
  assign cel_now = isc_q ? temp_q : f_cel;

  // ring
  logic [TW-1:0] ring_rd;
  logic          ring_we;
  assign ring_we = (state_q == S_UPD);

  ttm_ring #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ptr_q),
    .wdata_i (cel_now),
    .raddr_i (ptr_adj),
    .rdata_o (ring_rd)
  );

  // divider for sum / len
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVD_W-1:0] sum_mag;
  assign div_start = (state_q == S_DSTART);
  assign sum_mag   = sum_q[SUM_W-1] ? DVD_W'(-sum_q) : sum_q[DVD_W-1:0];

  ttm_divider #(
    .DVD_W (DVD_W),
    .DVS_W (WW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (len),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // signed average and trend compare
  logic [TW:0]            q17;
  logic signed [TW-1:0]   avg_now;
  logic signed [TW:0]     avg_diff;
  logic signed [TW:0]     thr17;
  assign q17      = div_quo[TW:0];
  assign avg_now  = sneg_q ? TW'(-q17) : q17[TW-1:0];
  assign avg_diff = {avg_now[TW-1], avg_now} - {prev_q[TW-1], prev_q};
  assign thr17    = $signed({2'b00, thr_q});

  logic full_now;
  assign full_now = (fill_q >= len);

  logic out_free;
  assign out_free = !m_vld_q || m_axis_tready;

  always_comb begin
    state_d    = state_q;
    win_d      = win_q;
    warn_hi_d  = warn_hi_q;
    warn_lo_d  = warn_lo_q;
    thr_d      = thr_q;
    ptr_d      = ptr_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    max_d      = max_q;
    prev_d     = prev_q;
    prev_vld_d = prev_vld_q;
    temp_d     = temp_q;
    isc_d      = isc_q;
    prod_d     = prod_q;
    fneg_d     = fneg_q;
    cel_d      = cel_q;
    oor_d      = oor_q;
    sneg_d     = sneg_q;
    avg_d      = avg_q;
    avg_vld_d  = avg_vld_q;
    trend_d    = trend_q;
    m_vld_d    = m_vld_q;
    m_data_d   = m_data_q;

    if (m_vld_q && m_axis_tready) begin
      m_vld_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        ttm_pkg::CFG_WINDOW_LENGTH: begin
          win_d      = cfg_wdata_i[WW-1:0];
          ptr_d      = '0;
          fill_d     = '0;
          sum_d      = '0;
          prev_vld_d = 1'b0;
        end
        ttm_pkg::CFG_WARN_HIGH:       warn_hi_d = cfg_wdata_i;
        ttm_pkg::CFG_WARN_LOW:        warn_lo_d = cfg_wdata_i;
        ttm_pkg::CFG_TREND_THRESHOLD: thr_d     = cfg_wdata_i[ttm_pkg::THR_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          temp_d  = s_axis_tdata;
          isc_d   = s_axis_tuser;
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        // registered reciprocal product; ring read at the wrapped pointer
        prod_d  = f_mag * ttm_pkg::RECIP_K;
        fneg_d  = f_x5[ttm_pkg::F_MAG_W];
        ptr_d   = ptr_adj;
        state_d = S_CONV == state_q ? S_UPD : S_CONV;
      end
      S_UPD: begin
        cel_d = cel_now;
        oor_d = (cel_now > warn_hi_q) || (cel_now < warn_lo_q);
        if (cel_now > max_q) begin
          max_d = cel_now;
        end
        if (full_now) begin
          sum_d  = sum_q - SUM_W'($signed(ring_rd)) + SUM_W'(cel_now);
          fill_d = len;
        end else begin
          sum_d  = sum_q + SUM_W'(cel_now);
          fill_d = fill_q + 1'b1;
        end
        ptr_d = (32'(ptr_q) + 1 >= 32'(len)) ? '0 : PTR_W'(ptr_q + 1'b1);
        if (full_now || (fill_q + 1'b1 >= len)) begin
          state_d = S_DSTART;
        end else begin
          avg_d     = '0;
          avg_vld_d = 1'b0;
          trend_d   = ttm_pkg::TREND_STABLE;
          state_d   = S_OUT;
        end
      end
      S_DSTART: begin
        sneg_d  = sum_q[SUM_W-1];
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_TREND;
        end
      end
      S_TREND: begin
        avg_d     = avg_now;
        avg_vld_d = 1'b1;
        trend_d   = ttm_pkg::TREND_STABLE;
        if (prev_vld_q) begin
          if (avg_diff > thr17) begin
            trend_d = ttm_pkg::TREND_RISING;
          end else if (avg_diff < -thr17) begin
            trend_d = ttm_pkg::TREND_FALLING;
          end
        end
        prev_d     = avg_now;
        prev_vld_d = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          m_vld_d  = 1'b1;
          m_data_d = {4'b0000, oor_q, trend_q, avg_vld_q, avg_q, max_q, cel_q};
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      win_q      <= ttm_pkg::WINDOW_RST;
      warn_hi_q  <= ttm_pkg::WARN_HIGH_RST;
      warn_lo_q  <= ttm_pkg::WARN_LOW_RST;
      thr_q      <= ttm_pkg::THR_RST;
      ptr_q      <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
      max_q      <= {1'b1, {(TW-1){1'b0}}};
      prev_q     <= '0;
      prev_vld_q <= 1'b0;
      m_vld_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      win_q      <= win_d;
      warn_hi_q  <= warn_hi_d;
      warn_lo_q  <= warn_lo_d;
      thr_q      <= thr_d;
      ptr_q      <= ptr_d;
      fill_q     <= fill_d;
      sum_q      <= sum_d;
      max_q      <= max_d;
      prev_q     <= prev_d;
      prev_vld_q <= prev_vld_d;
      m_vld_q    <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q    <= temp_d;
    isc_q     <= isc_d;
    prod_q    <= prod_d;
    fneg_q    <= fneg_d;
    cel_q     <= cel_d;
    oor_q     <= oor_d;
    sneg_q    <= sneg_d;
    avg_q     <= avg_d;
    avg_vld_q <= avg_vld_d;
    trend_q   <= trend_d;
    m_data_q  <= m_data_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== design/ttm_checker.sv =====
// ----------------------------------------------------------------------------
// ttm_checker
// Port-level assertions for the temperature trend monitor, bound to the core.
// ----------------------------------------------------------------------------
module ttm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ttm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // one sample at a time: input closes right after a transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready after accepted transaction");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no average means zero average and stable trend
  a_invalid_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[48] |->
      m_axis_tdata[47:32] == '0 && m_axis_tdata[50:49] == ttm_pkg::TREND_STABLE)
    else $error("average or trend set without valid average");

  // trend code in range
  a_trend_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[50] && m_axis_tdata[49]))
    else $error("bad trend code");

  // running max never below the current sample
  a_max_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[31:16]) >= $signed(m_axis_tdata[15:0]))
    else $error("max_seen below celsius");

endmodule

bind temperature_trend_monitor_core ttm_checker u_ttm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/temperature_trend_monitor_core_test.sv =====
// ----------------------------------------------------------------------------
// temperature_trend_monitor_core_test
// Self-checking bench for the temperature trend monitor. Samples are streamed
// in, every result transaction is checked field by field against an in-bench
// model of the conversion, running max, moving average, trend and limit
// flags. Directed tests first, then random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module temperature_trend_monitor_core_test;

  localparam int CLK_PERIOD = 8;
  localparam int RING_DEPTH = 64;      // MAX_WINDOW of the instance
  localparam int F_BASE     = 32 * 16; // 32 F in 1/16 degree
  localparam int F_MUL      = 5;
  localparam int F_DIV      = 9;
  localparam int DRAIN_WAIT = 40;      // > one sample through the divider

  typedef struct packed {
    logic [ttm_pkg::TEMP_W-1:0] celsius;
    logic [ttm_pkg::TEMP_W-1:0] max_seen;
    logic [ttm_pkg::TEMP_W-1:0] average;
    logic                       avg_valid;
    ttm_pkg::trend_e            trend;
    logic                       out_of_range;
  } reading_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [ttm_pkg::TEMP_W-1:0]      s_axis_tdata = '0;  // [15:0] temp_value
  logic                            s_axis_tuser = 1'b0; // [0] unit_is_c
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [15:0] celsius, [31:16] max_seen, [47:32] average, [48] average_valid,
  // [50:49] trend, [51] out_of_range
  logic [ttm_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            cfg_we_i = 1'b0;
  logic [ttm_pkg::CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [ttm_pkg::CFG_W-1:0]       cfg_wdata_i = '0;

  temperature_trend_monitor_core #(.MAX_WINDOW(RING_DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Model state: register copies plus the averaging window, updated as
  // samples are accepted and registers are written.
  // --------------------------------------------------------------------------
  logic [ttm_pkg::WIN_W-1:0] win_len   = ttm_pkg::WINDOW_RST;
  int                        warn_hi   = 800;
  int                        warn_lo   = 160;
  int                        trend_thr = 6;

  shortint ring [RING_DEPTH];
  int      ring_wptr  = 0;
  int      ring_fill  = 0;
  int      ring_sum   = 0;
  int      max_c      = -32768;
  int      prev_avg   = 0;
  bit      prev_valid = 1'b0;

  reading_t predicted_readings[$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       walk_level     = 400;  // random-walk temperature, 25 C

  // Compute the result of one accepted sample and advance the model state.
  function automatic reading_t predict_reading(logic [ttm_pkg::TEMP_W-1:0] raw,
                                               logic is_c);
    reading_t r;
    int t, c, len, avg, diff;
    t = $signed(raw);
    // int division truncates toward zero, as the block does
    c = is_c ? t : ((t - F_BASE) * F_MUL) / F_DIV;
    if (c > max_c) max_c = c;

    // zero acts as one, anything past the ring depth as the full ring
    len = (win_len == 0) ? 1 : ((int'(win_len) > RING_DEPTH) ? RING_DEPTH : int'(win_len));
    if (ring_wptr >= len) ring_wptr = 0;
    if (ring_fill >= len) begin
      ring_sum -= ring[ring_wptr];
      ring_fill = len;
    end else begin
      ring_fill++;
    end
    ring[ring_wptr] = shortint'(c);
    ring_sum += c;
    ring_wptr = (ring_wptr + 1 >= len) ? 0 : ring_wptr + 1;

    avg         = 0;
    r.avg_valid = 1'b0;
    r.trend     = ttm_pkg::TREND_STABLE;
    if (ring_fill >= len) begin
      avg         = ring_sum / len;
      r.avg_valid = 1'b1;
      // first valid average after a restart has nothing to compare against
      if (prev_valid) begin
        diff = avg - prev_avg;
        if (diff > trend_thr) r.trend = ttm_pkg::TREND_RISING;
        else if (diff < -trend_thr) r.trend = ttm_pkg::TREND_FALLING;
      end
      prev_avg   = avg;
      prev_valid = 1'b1;
    end

    // limits are tested independently, so crossed limits flag both ways
    r.out_of_range = (c > warn_hi) || (c < warn_lo);
    r.celsius      = ttm_pkg::TEMP_W'(c);
    r.max_seen     = ttm_pkg::TEMP_W'(max_c);
    r.average      = ttm_pkg::TEMP_W'(avg);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // --------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    mismatch_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name,
                             input logic [ttm_pkg::TEMP_W-1:0] got_v,
                             input logic [ttm_pkg::TEMP_W-1:0] want_v);
    if (got_v !== want_v)
      flag_error($sformatf("%s got %0d expected %0d", name, $signed(got_v),
                           $signed(want_v)));
  endtask

  task automatic check_reading(input logic [ttm_pkg::OUT_TDATA_W-1:0] data);
    reading_t want;
    if (predicted_readings.size() == 0) begin
      flag_error($sformatf("unexpected result transaction %h", data));
    end else begin
      want = predicted_readings.pop_front();
      check_field("celsius", data[15:0], want.celsius);
      check_field("max_seen", data[31:16], want.max_seen);
      check_field("average", data[47:32], want.average);
      check_field("average_valid", ttm_pkg::TEMP_W'(data[48]),
                  ttm_pkg::TEMP_W'(want.avg_valid));
      check_field("trend", ttm_pkg::TEMP_W'(data[50:49]),
                  ttm_pkg::TEMP_W'(want.trend));
      check_field("out_of_range", ttm_pkg::TEMP_W'(data[51]),
                  ttm_pkg::TEMP_W'(want.out_of_range));
    end
  endtask

  // Result side: sampled at the rising edge, values are those before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_reading(m_axis_tdata);
  end

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One input transaction. tvalid stays high on return so back-to-back
  // samples need no bubble; settle() or an idle draw drops it.
  task automatic send_reading(input logic [ttm_pkg::TEMP_W-1:0] temp, input logic is_c);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= temp;
    s_axis_tuser  <= is_c;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted_readings.push_back(predict_reading(temp, is_c));
  endtask

  // Stop sending, wait for every outstanding result, then let the block go idle.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (predicted_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Register write, only called once the block is idle.
  task automatic apply_setting(input logic [ttm_pkg::CFG_IDX_W-1:0] idx,
                               input logic [ttm_pkg::CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      ttm_pkg::CFG_WINDOW_LENGTH: begin
        // any window write restarts the average
        win_len    = value[ttm_pkg::WIN_W-1:0];
        ring_wptr  = 0;
        ring_fill  = 0;
        ring_sum   = 0;
        prev_valid = 1'b0;
      end
      ttm_pkg::CFG_WARN_HIGH:       warn_hi = $signed(value);
      ttm_pkg::CFG_WARN_LOW:        warn_lo = $signed(value);
      ttm_pkg::CFG_TREND_THRESHOLD: trend_thr = int'(value[ttm_pkg::THR_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  // Reset settings (window 10, limits 800/160): conversion extremes and
  // truncation toward zero, max tracking from the reset value, window fill,
  // first valid average, limit edges.
  task automatic test_reset_and_conversion();
    send_reading(16'sh8000, 1'b0);  // coldest Fahrenheit
    send_reading(16'sh8000, 1'b1);  // equal to reset max, no update
    send_reading(16'd0, 1'b0);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'd504, 1'b0);    // -40/9 truncates to -4
    send_reading(16'd520, 1'b0);    //  40/9 truncates to 4
    send_reading(16'sh7FFF, 1'b0);  // hottest Fahrenheit
    send_reading(16'd512, 1'b0);    // exactly 0 C
    send_reading(16'd800, 1'b1);    // on warn_high, not flagged
    send_reading(16'd801, 1'b1);    // window full here: first valid average
    send_reading(16'd160, 1'b1);    // on warn_low, not flagged
    send_reading(16'd159, 1'b1);
    settle();
  endtask

  // Window clamp and restart, trend at and just past the threshold.
  task automatic test_window_and_trend();
    apply_setting(ttm_pkg::CFG_TREND_THRESHOLD, 16'd10);
    apply_setting(ttm_pkg::CFG_WINDOW_LENGTH, 16'd0);  // acts as one
    send_reading(16'd0, 1'b1);
    send_reading(16'd10, 1'b1);   // diff equals threshold: stable
    send_reading(16'd21, 1'b1);   // rising
    send_reading(16'd10, 1'b1);   // falling
    send_reading(16'd0, 1'b1);    // diff equals minus threshold: stable
    settle();
    apply_setting(ttm_pkg::CFG_WINDOW_LENGTH, 16'd2);  // restart drops the old average
    send_reading(16'd100, 1'b1);
    send_reading(16'd200, 1'b1);  // first valid after restart: stable
    send_reading(16'd300, 1'b1);
    settle();
  endtask

  // Limit boundaries, crossed limits, register extremes.
  task automatic test_limit_extremes();
    apply_setting(ttm_pkg::CFG_WINDOW_LENGTH, 16'd1);
    apply_setting(ttm_pkg::CFG_WARN_HIGH, 16'd100);
    apply_setting(ttm_pkg::CFG_WARN_LOW, -16'sd100);
    send_reading(16'd101, 1'b1);
    send_reading(-16'sd101, 1'b1);
    settle();
    apply_setting(ttm_pkg::CFG_WARN_HIGH, -16'sd200);  // crossed: every sample flagged
    apply_setting(ttm_pkg::CFG_WARN_LOW, 16'd200);
    send_reading(16'd0, 1'b1);
    settle();
    apply_setting(ttm_pkg::CFG_WARN_HIGH, 16'sh7FFF);
    apply_setting(ttm_pkg::CFG_WARN_LOW, 16'sh8000);
    apply_setting(ttm_pkg::CFG_TREND_THRESHOLD, 16'h7FFF);
    send_reading(16'sh7FFF, 1'b1);  // diff equals largest threshold: stable
    send_reading(16'sh8000, 1'b1);  // full-scale drop: falling
    settle();
    apply_setting(ttm_pkg::CFG_TREND_THRESHOLD, 16'd0);
    send_reading(16'sh8000, 1'b1);  // no change: stable
    send_reading(16'sh8001, 1'b1);  // one step up: rising
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------
  // Mostly a random walk so averages stay meaningful and trends flip both
  // ways; the rest are room temperatures in Fahrenheit and full-range noise.
  task automatic pick_sample(output logic [ttm_pkg::TEMP_W-1:0] temp, output logic is_c);
    int mode, step_max;
    mode = $urandom_range(99);
    if (mode < 55) begin
      step_max = (trend_thr > 1000) ? 1000 : 3 * trend_thr + 8;
      walk_level += int'($urandom_range(2 * step_max)) - step_max;
      if (walk_level > 32767) walk_level = 32767;
      if (walk_level < -32768) walk_level = -32768;
      temp = ttm_pkg::TEMP_W'(walk_level);
      is_c = 1'b1;
    end else if (mode < 70) begin
      temp = ttm_pkg::TEMP_W'($urandom_range(3200));  // 0 to 200 F
      is_c = 1'b0;
    end else begin
      temp = ttm_pkg::TEMP_W'($urandom());
      is_c = 1'(($urandom_range(1)));
    end
  endtask

  // New register settings; the window is left alone now and then so the
  // average runs on across phases.
  task automatic shuffle_settings();
    int sel;
    sel = $urandom_range(9);
    if ($urandom_range(9) < 7) begin
      if (sel == 0) apply_setting(ttm_pkg::CFG_WINDOW_LENGTH, 16'd0);
      else if (sel == 1) apply_setting(ttm_pkg::CFG_WINDOW_LENGTH, 16'd64);
      else if (sel == 2)
        apply_setting(ttm_pkg::CFG_WINDOW_LENGTH, ttm_pkg::CFG_W'($urandom_range(65, 127)));
      else if (sel == 3)  // upper bits ignored
        apply_setting(ttm_pkg::CFG_WINDOW_LENGTH, ttm_pkg::CFG_W'($urandom()));
      else apply_setting(ttm_pkg::CFG_WINDOW_LENGTH, ttm_pkg::CFG_W'($urandom_range(1, 12)));
    end
    sel = $urandom_range(9);
    if (sel == 0) apply_setting(ttm_pkg::CFG_TREND_THRESHOLD, 16'd0);
    else if (sel == 1) apply_setting(ttm_pkg::CFG_TREND_THRESHOLD, 16'h7FFF);
    else if (sel == 2) apply_setting(ttm_pkg::CFG_TREND_THRESHOLD, ttm_pkg::CFG_W'($urandom()));
    else apply_setting(ttm_pkg::CFG_TREND_THRESHOLD, ttm_pkg::CFG_W'($urandom_range(40)));
    // limits usually bracket the walk so the flag toggles
    if ($urandom_range(9) < 2) begin
      apply_setting(ttm_pkg::CFG_WARN_HIGH, ttm_pkg::CFG_W'($urandom()));
      apply_setting(ttm_pkg::CFG_WARN_LOW, ttm_pkg::CFG_W'($urandom()));
    end else begin
      apply_setting(ttm_pkg::CFG_WARN_HIGH,
                    ttm_pkg::CFG_W'(walk_level + int'($urandom_range(200))));
      apply_setting(ttm_pkg::CFG_WARN_LOW,
                    ttm_pkg::CFG_W'(walk_level - int'($urandom_range(200))));
    end
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
    int sent, chunk;
    logic [ttm_pkg::TEMP_W-1:0] temp;
    logic is_c;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_items) begin
      shuffle_settings();
      chunk = $urandom_range(30, 120);
      for (int i = 0; i < chunk && sent < n_items; i++) begin
        pick_sample(temp, is_c);
        send_reading(temp, is_c);
        sent++;
      end
      settle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_and_conversion();
    test_window_and_trend();
    test_limit_extremes();
    test_random_traffic(340, 0, 0);
    test_random_traffic(340, 87, 0);
    test_random_traffic(340, 0, 87);
    test_random_traffic(340, 27, 27);

    settle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(CLK_PERIOD * 1_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ttm_pkg.sv
design/ttm_divider.sv
design/ttm_ring.sv
design/temperature_trend_monitor_core.sv
design/ttm_checker.sv
tb/temperature_trend_monitor_core_test.sv
